// ----- hdl/dqne_pkg.sv -----
// dqne_pkg: constants, types and byte tables for the dns query name encoder
// used by hdl/dns_query_name_encoder.sv, no dependencies
package dqne_pkg;

	localparam int ADDR_W      = 9;
	localparam int LEN_W       = 7;
	localparam int HDR_LEN     = 12;
	localparam int MAX_LABEL   = 63;
	localparam int MAX_NAME    = 255;
	localparam logic [7:0] DOT = 8'h2e;

	// write steps of one item, in emission order
	localparam int N_STEPS   = 19;
	localparam int STEP_W    = 5;
	localparam int STEP_DATA = 12;
	localparam int STEP_LEN  = 13;
	localparam int STEP_TRL  = 14;
	localparam int STEP_LAST = 18;

	localparam int IN_DATA_W  = 8;
	localparam int OUT_DATA_W = 24;

	typedef logic [N_STEPS-1:0] step_mask_t;

	// everything an accepted item still has to write
	typedef struct packed {
		step_mask_t              mask;
		logic [ADDR_W-1:0]       data_addr;
		logic [7:0]              data_byte;
		logic [ADDR_W-1:0]       len_addr;
		logic [7:0]              len_byte;
		logic [ADDR_W-1:0]       term_addr;
		logic                    ovf;
	} job_t;

	// fixed header: id, flags 0x0100, one question, zero counts
	function automatic logic [7:0] hdr_byte(input logic [3:0] k, input logic [15:0] qid);
		logic [7:0] b;
		b = 8'h00;
		unique case (k)
			4'd0:    b = qid[15:8];
			4'd1:    b = qid[7:0];
			4'd2:    b = 8'h01;
			4'd5:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	// terminator, type a, class in
	function automatic logic [7:0] trl_byte(input logic [2:0] k);
		logic [7:0] b;
		b = 8'h00;
		unique case (k)
			3'd2:    b = 8'h01;
			3'd4:    b = 8'h01;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

// ----- hdl/dns_query_name_encoder.sv -----
// dns_query_name_encoder: top level, builds dns query packet writes from a host name
// depends on hdl/dqne_pkg.sv
//
// usage: characters of a dotted host name arrive on the s_axis channel, one per transfer,
// with tuser marking the first character of a name and tlast the final one. each transfer
// on m_axis is one (address, byte) write into a packet buffer; tlast marks the final write
// of the packet and tuser carries the sticky overflow flag of the current name.
// cfg_data sets the query id; the user must write it only while the block is idle, the block does not check.
// an accepted character is checked against label and name limits in the accept cycle and
// queued as a small job; a job register feeds one write per cycle into an output register.
// the first write of an item passes through the job register and then the output register before m_axis.
// throughput: one item per cycle for plain characters while m_axis does not stall; an item holds
// the job register until all its writes have left, so the first character of a name causes at least
// 13 writes (header) and the final one up to 7 (length byte and trailer).
// a dropped mid-name character takes only its transfer. a stalled m_axis holds the output register;
// the job register still takes one more item, then s_axis_tready drops until the job drains.
// reset clears the label state, the query id and both valid flags; nothing is in flight.
module dns_query_name_encoder (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [dqne_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // [7:0] name_char
	input  logic                             s_axis_tuser,   // [0] first_char
	input  logic                             s_axis_tlast,   // last_char
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	output logic [dqne_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // [8:0] write_address, [16:9] write_byte, zero pad
	output logic                             m_axis_tuser,   // [0] overflow
	output logic                             m_axis_tlast,   // packet_done
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [15:0]                      cfg_data
);

	localparam int AW = dqne_pkg::ADDR_W;
	localparam int LW = dqne_pkg::LEN_W;

	logic [15:0]     query_id_q;
	logic [AW-1:0]   label_start_q;
	logic [LW-1:0]   label_length_q;
	logic            ovf_q;

	logic            job_valid_s1;
	dqne_pkg::job_t  job_s1;
	logic            out_valid_s2;
	logic [AW-1:0]   out_addr_s2;
	logic [7:0]      out_byte_s2;
	logic            out_done_s2;
	logic            out_ovf_s2;

	logic            accept;
	logic            emit;
	logic            job_free;

	// front end: next label state and the job for the incoming character
	logic [7:0]      ch;
	logic            first, last;
	logic [AW-1:0]   ls0, ls1;
	logic [LW-1:0]   ll0, ll1;
	logic            ov1;
	logic [AW:0]     pos, used;
	logic            room, closed;
	dqne_pkg::job_t  job_d;

	assign ch    = s_axis_tdata[7:0];
	assign first = s_axis_tuser;
	assign last  = s_axis_tlast;

	always_comb begin
		ls0    = first ? AW'(dqne_pkg::HDR_LEN) : label_start_q;
		ll0    = first ? '0 : label_length_q;
		ov1    = first ? 1'b0 : ovf_q;
		ls1    = ls0;
		ll1    = ll0;
		closed = 1'b0;
		job_d  = '0;
		pos    = {1'b0, ls0} + (AW+1)'(1) + (AW+1)'(ll0);
		used   = (pos >= (AW+1)'(dqne_pkg::HDR_LEN))
			? pos - (AW+1)'(dqne_pkg::HDR_LEN - 2) : (AW+1)'(2);
		room   = used <= (AW+1)'(dqne_pkg::MAX_NAME);
		job_d.mask[dqne_pkg::STEP_DATA-1:0] = {dqne_pkg::STEP_DATA{first}};
		if (ch == dqne_pkg::DOT) begin
			if (room) begin
				job_d.mask[dqne_pkg::STEP_DATA] = 1'b1;
				job_d.data_addr = ls0;
				job_d.data_byte = 8'(ll0);
				ls1    = pos[AW-1:0];
				ll1    = '0;
				closed = 1'b1;
			end else begin
				ov1 = 1'b1;
			end
		end else begin
			if (room && (ll0 < LW'(dqne_pkg::MAX_LABEL))) begin
				job_d.mask[dqne_pkg::STEP_DATA] = 1'b1;
				job_d.data_addr = pos[AW-1:0];
				job_d.data_byte = ch;
				ll1 = ll0 + LW'(1);
			end else begin
				ov1 = 1'b1;
			end
		end
		job_d.len_addr  = ls1;
		job_d.len_byte  = 8'(ll1);
		job_d.term_addr = closed ? ls1 : ls1 + AW'(1) + AW'(ll1);
		job_d.ovf       = ov1;
		if (last) begin
			job_d.mask[dqne_pkg::STEP_LEN] = !closed;
			job_d.mask[dqne_pkg::STEP_LAST:dqne_pkg::STEP_TRL] = '1;
		end
	end

	// back end: lowest pending step of the job goes out next
	logic [dqne_pkg::STEP_W-1:0] sel;
	dqne_pkg::step_mask_t        mask_next;
	logic [AW-1:0]               sel_addr;
	logic [7:0]                  sel_byte;
	logic [2:0]                  trl_k;

	always_comb begin
		sel = '0;
		for (int k = dqne_pkg::N_STEPS - 1; k >= 0; k--) begin
			if (job_s1.mask[k]) begin
				sel = dqne_pkg::STEP_W'(k);
			end
		end
		mask_next      = job_s1.mask;
		mask_next[sel] = 1'b0;
		trl_k    = 3'(sel - dqne_pkg::STEP_W'(dqne_pkg::STEP_TRL));
		sel_addr = AW'(sel);
		sel_byte = dqne_pkg::hdr_byte(sel[3:0], query_id_q);
		if (sel == dqne_pkg::STEP_W'(dqne_pkg::STEP_DATA)) begin
			sel_addr = job_s1.data_addr;
			sel_byte = job_s1.data_byte;
		end else if (sel == dqne_pkg::STEP_W'(dqne_pkg::STEP_LEN)) begin
			sel_addr = job_s1.len_addr;
			sel_byte = job_s1.len_byte;
		end else if (sel >= dqne_pkg::STEP_W'(dqne_pkg::STEP_TRL)) begin
			sel_addr = job_s1.term_addr + AW'(trl_k);
			sel_byte = dqne_pkg::trl_byte(trl_k);
		end
	end

	assign emit          = job_valid_s1 && (!out_valid_s2 || m_axis_tready);
	assign job_free      = emit && (mask_next == '0);
	assign s_axis_tready = !job_valid_s1 || job_free;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_id_q     <= '0;
			label_start_q  <= AW'(dqne_pkg::HDR_LEN);
			label_length_q <= '0;
			ovf_q          <= 1'b0;
			job_valid_s1   <= 1'b0;
			out_valid_s2   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				query_id_q <= cfg_data;
			end
			if (accept) begin
				if (last) begin
					label_start_q  <= AW'(dqne_pkg::HDR_LEN);
					label_length_q <= '0;
					ovf_q          <= 1'b0;
				end else begin
					label_start_q  <= ls1;
					label_length_q <= ll1;
					ovf_q          <= ov1;
				end
				// a dropped character with no marks leaves nothing to write
				job_valid_s1 <= (job_d.mask != '0);
			end else if (job_free) begin
				job_valid_s1 <= 1'b0;
			end
			if (emit) begin
				out_valid_s2 <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			job_s1 <= job_d;
		end else if (emit) begin
			job_s1.mask <= mask_next;
		end
		if (emit) begin
			out_addr_s2 <= sel_addr;
			out_byte_s2 <= sel_byte;
			out_done_s2 <= (sel == dqne_pkg::STEP_W'(dqne_pkg::STEP_LAST));
			out_ovf_s2  <= job_s1.ovf;
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {(dqne_pkg::OUT_DATA_W - AW - 8)'(0), out_byte_s2, out_addr_s2};
	assign m_axis_tlast  = out_done_s2;
	assign m_axis_tuser  = out_ovf_s2;

`ifndef SYNTHESIS
	a_job_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid_s1 |-> (job_s1.mask != '0))
		else $error("job held with no pending write");

	a_first_header: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tuser) |=> (job_valid_s1 && job_s1.mask[0]))
		else $error("first character did not queue the header");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_axis_tlast) |=> (label_start_q == AW'(dqne_pkg::HDR_LEN)
			&& label_length_q == '0 && !ovf_q))
		else $error("label state not cleared after final character");

	a_done_last_step: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && sel == dqne_pkg::STEP_W'(dqne_pkg::STEP_LAST)) |-> (mask_next == '0))
		else $error("packet done write not the final write of its job");
`endif

endmodule

// ----- sim/dqne_checker.sv -----
// dqne_checker: watches the name, write and query id channels of the dns query name encoder,
// predicts every packet write and compares it field by field with what the block sends
// depends on hdl/dqne_pkg.sv
module dqne_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [dqne_pkg::IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] name_char
	input  logic                            s_axis_tuser,   // [0] first_char
	input  logic                            s_axis_tlast,   // last_char
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [dqne_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // [8:0] write_address, [16:9] write_byte, zero pad
	input  logic                            m_axis_tuser,   // [0] overflow
	input  logic                            m_axis_tlast,   // packet_done
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [15:0]                     cfg_data,
	output int                              errors,
	output int                              pending,
	output int                              writes_checked,
	output int                              packets_closed,
	output int                              overflow_writes
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [15:0] FLAGS_RD  = 16'h0100;
	localparam logic [15:0] QD_COUNT  = 16'h0001;
	localparam logic [15:0] QTYPE_A   = 16'h0001;
	localparam logic [15:0] QCLASS_IN = 16'h0001;
	localparam int          REPORT_MAX = 10;

	typedef struct {
		logic [dqne_pkg::ADDR_W-1:0] addr;
		logic [7:0]                  data;
		logic                        done;
		logic                        ovf;
	} pkt_write_t;

	pkt_write_t                  expected_writes[$];
	logic [15:0]                 txn_id;
	logic [dqne_pkg::ADDR_W-1:0] label_base;
	logic [dqne_pkg::LEN_W-1:0]  label_fill;
	logic                        dropped_any;

	function automatic void add_write(input int a, input logic [7:0] d);
		pkt_write_t w;
		w.addr = dqne_pkg::ADDR_W'(a);
		w.data = d;
		w.done = 1'b0;
		w.ovf  = 1'b0;
		expected_writes.push_back(w);
	endfunction

	// all writes one accepted character causes, in the order they leave the block
	function automatic void encode_char(input logic [7:0] ch, input logic first_c,
			input logic last_c);
		int   base, k, pos, term;
		logic closed, room, ovf;
		base   = expected_writes.size();
		closed = 1'b0;
		if (first_c) begin
			label_base  = dqne_pkg::ADDR_W'(dqne_pkg::HDR_LEN);
			label_fill  = '0;
			dropped_any = 1'b0;
			for (k = 0; k < dqne_pkg::HDR_LEN; k++) begin
				case (k)
					0:       add_write(k, txn_id[15:8]);
					1:       add_write(k, txn_id[7:0]);
					2:       add_write(k, FLAGS_RD[15:8]);
					3:       add_write(k, FLAGS_RD[7:0]);
					4:       add_write(k, QD_COUNT[15:8]);
					5:       add_write(k, QD_COUNT[7:0]);
					default: add_write(k, 8'h00);
				endcase
			end
		end
		pos = int'(label_base) + 1 + int'(label_fill);
		// encoded name size if this byte is kept, terminator included
		room = (pos - dqne_pkg::HDR_LEN + 2) <= dqne_pkg::MAX_NAME;
		if (ch == dqne_pkg::DOT) begin
			if (room) begin
				add_write(int'(label_base), 8'(label_fill));
				label_base = dqne_pkg::ADDR_W'(pos);
				label_fill = '0;
				closed     = 1'b1;
			end else begin
				dropped_any = 1'b1;
			end
		end else if (room && int'(label_fill) < dqne_pkg::MAX_LABEL) begin
			add_write(pos, ch);
			label_fill = label_fill + 1'b1;
		end else begin
			dropped_any = 1'b1;
		end
		ovf = dropped_any;
		if (last_c) begin
			// a kept trailing dot leaves an empty label whose slot takes the terminator
			if (closed) begin
				term = int'(label_base);
			end else begin
				add_write(int'(label_base), 8'(label_fill));
				term = int'(label_base) + 1 + int'(label_fill);
			end
			add_write(term, 8'h00);
			add_write(term + 1, QTYPE_A[15:8]);
			add_write(term + 2, QTYPE_A[7:0]);
			add_write(term + 3, QCLASS_IN[15:8]);
			add_write(term + 4, QCLASS_IN[7:0]);
			expected_writes[expected_writes.size() - 1].done = 1'b1;
			label_base  = dqne_pkg::ADDR_W'(dqne_pkg::HDR_LEN);
			label_fill  = '0;
			dropped_any = 1'b0;
		end
		for (k = base; k < expected_writes.size(); k++)
			expected_writes[k].ovf = ovf;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		pkt_write_t got, want;
		if (!arst_n) begin
			expected_writes.delete();
			txn_id          = '0;
			label_base      = dqne_pkg::ADDR_W'(dqne_pkg::HDR_LEN);
			label_fill      = '0;
			dropped_any     = 1'b0;
			errors          = 0;
			pending         = 0;
			writes_checked  = 0;
			packets_closed  = 0;
			overflow_writes = 0;
		end else begin
			if (cfg_valid && cfg_ready)
				txn_id = cfg_data;

			if (m_axis_tvalid && m_axis_tready) begin
				got.addr = m_axis_tdata[dqne_pkg::ADDR_W-1:0];
				got.data = m_axis_tdata[dqne_pkg::ADDR_W+7:dqne_pkg::ADDR_W];
				got.done = m_axis_tlast;
				got.ovf  = m_axis_tuser;
				writes_checked++;
				if (got.done)
					packets_closed++;
				if (got.ovf)
					overflow_writes++;
				if (expected_writes.size() == 0) begin
					if (errors < REPORT_MAX)
						$display("%t: unexpected write addr %0d byte %02h done %0b ovf %0b",
							$realtime, got.addr, got.data, got.done, got.ovf);
					errors++;
				end else begin
					want = expected_writes.pop_front();
					if (got.addr !== want.addr || got.data !== want.data ||
							got.done !== want.done || got.ovf !== want.ovf) begin
						if (errors < REPORT_MAX) begin
							$write("%t: write %0d expected addr %0d byte %02h done %0b ovf %0b,",
								$realtime, writes_checked, want.addr, want.data, want.done,
								want.ovf);
							$display(" got addr %0d byte %02h done %0b ovf %0b",
								got.addr, got.data, got.done, got.ovf);
						end
						errors++;
					end
				end
			end

			if (s_axis_tvalid && s_axis_tready)
				encode_char(s_axis_tdata[7:0], s_axis_tuser, s_axis_tlast);

			pending = expected_writes.size();
		end
	end

endmodule

// ----- sim/testbench.sv -----
// testbench: drives host names into dns_query_name_encoder, stalls the write side at random
// and leaves prediction and comparison to dqne_checker
// depends on hdl/dqne_pkg.sv, hdl/dns_query_name_encoder.sv, sim/dqne_checker.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ITEM_TARGET = 465;
	localparam int PHASE_ITEMS = 60;
	localparam int QUIET_LIMIT = 1000;
	localparam int SETTLE      = 8;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [dqne_pkg::IN_DATA_W-1:0]  s_axis_tdata;
	logic                            s_axis_tuser;
	logic                            s_axis_tlast;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [dqne_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic                            m_axis_tuser;
	logic                            m_axis_tlast;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [15:0]                     cfg_data;

	int errors, pending, writes_checked, packets_closed, overflow_writes;
	int chars_sent, id_writes, gap_pct, stall_pct, quiet_cycles, next_phase;

	dns_query_name_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	dqne_checker chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_axis_tvalid   (s_axis_tvalid),
		.s_axis_tready   (s_axis_tready),
		.s_axis_tdata    (s_axis_tdata),
		.s_axis_tuser    (s_axis_tuser),
		.s_axis_tlast    (s_axis_tlast),
		.m_axis_tvalid   (m_axis_tvalid),
		.m_axis_tready   (m_axis_tready),
		.m_axis_tdata    (m_axis_tdata),
		.m_axis_tuser    (m_axis_tuser),
		.m_axis_tlast    (m_axis_tlast),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.errors          (errors),
		.pending         (pending),
		.writes_checked  (writes_checked),
		.packets_closed  (packets_closed),
		.overflow_writes (overflow_writes)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// write side: ready stretches broken by stall bursts
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			m_axis_tready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if ($urandom_range(0, 99) < stall_pct) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%t: no transfer for %0d cycles", $realtime, QUIET_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	function automatic logic [7:0] rand_char();
		logic [7:0] c;
		do
			c = 8'($urandom_range(0, 255));
		while (c == dqne_pkg::DOT);
		return c;
	endfunction

	task automatic send_char(input logic [7:0] ch, input logic first_c, input logic last_c);
		if ($urandom_range(0, 99) < gap_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= ch;
		s_axis_tuser  <= first_c;
		s_axis_tlast  <= last_c;
		do
			@(posedge clk);
		while (!s_axis_tready);
		chars_sent++;
	endtask

	// dotted name; a label length of zero makes an empty label
	task automatic send_name(input int nlab, input int fixed_len, input bit mark_first,
			input bit trail_dot);
		int lens[4];
		int total, idx, i, j;
		bit tdot;
		total = 0;
		tdot  = trail_dot;
		for (i = 0; i < nlab; i++) begin
			if (fixed_len >= 0)
				lens[i] = fixed_len;
			else if ($urandom_range(0, 99) < 3)
				lens[i] = $urandom_range(60, 70);
			else if ($urandom_range(0, 99) < 10)
				lens[i] = 0;
			else
				lens[i] = $urandom_range(1, 10);
			total += lens[i];
		end
		total += nlab - 1;
		if (total == 0)
			tdot = 1'b1;
		total += tdot;
		idx = 0;
		for (i = 0; i < nlab; i++) begin
			if (i > 0) begin
				send_char(dqne_pkg::DOT, mark_first && idx == 0, idx == total - 1);
				idx++;
			end
			for (j = 0; j < lens[i]; j++) begin
				send_char(rand_char(), mark_first && idx == 0, idx == total - 1);
				idx++;
			end
		end
		if (tdot)
			send_char(dqne_pkg::DOT, mark_first && idx == 0, 1'b1);
	endtask

	// arbitrary characters and marks, dots frequent
	task automatic send_noise();
		int n;
		n = $urandom_range(1, 8);
		repeat (n)
			send_char(($urandom_range(0, 3) == 0) ? dqne_pkg::DOT : 8'($urandom_range(0, 255)),
				$urandom_range(0, 9) == 0, $urandom_range(0, 7) == 0);
	endtask

	// sender holds off until every predicted write has come back
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_id(input logic [15:0] id);
		cfg_valid <= 1'b1;
		cfg_data  <= id;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		id_writes++;
	endtask

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		s_axis_tlast  = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		chars_sent    = 0;
		id_writes     = 0;
		gap_pct       = 0;
		stall_pct     = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		write_id(16'hFFFF);
		send_char("a", 1'b1, 1'b0);
		send_char(dqne_pkg::DOT, 1'b0, 1'b0);
		send_char("b", 1'b0, 1'b1);
		// one-character name, zero byte as an ordinary character
		send_char(8'h00, 1'b1, 1'b1);
		// leading dot, empty label, trailing dot
		send_char(dqne_pkg::DOT, 1'b1, 1'b0);
		send_char(dqne_pkg::DOT, 1'b0, 1'b0);
		send_char("x", 1'b0, 1'b0);
		send_char(dqne_pkg::DOT, 1'b0, 1'b1);
		send_char(dqne_pkg::DOT, 1'b1, 1'b1);
		send_char(8'hFF, 1'b1, 1'b0);
		send_char(8'h7F, 1'b0, 1'b0);
		send_char(8'h80, 1'b0, 1'b1);
		// no first mark after a finished packet
		send_char("q", 1'b0, 1'b0);
		send_char(dqne_pkg::DOT, 1'b0, 1'b0);
		send_char("r", 1'b0, 1'b1);
		// first mark again in the middle of a name
		send_char("m", 1'b1, 1'b0);
		send_char("n", 1'b1, 1'b0);
		send_char("o", 1'b0, 1'b1);
		drain();
		write_id(16'h0000);
		send_char("z", 1'b1, 1'b1);

		// labels over the label limit in a name that runs past the name limit, then a short name
		gap_pct   = 15;
		stall_pct = 30;
		drain();
		write_id(16'($urandom_range(0, 65535)));
		send_name(4, 64, 1'b1, 1'b1);
		send_name(2, 3, 1'b1, 1'b0);

		next_phase = chars_sent;
		while (chars_sent < ITEM_TARGET) begin
			if (chars_sent >= next_phase && chars_sent <= ITEM_TARGET - PHASE_ITEMS) begin
				drain();
				case ($urandom_range(0, 3))
					0:       write_id(16'h0000);
					1:       write_id(16'hFFFF);
					default: write_id(16'($urandom_range(0, 65535)));
				endcase
				case ($urandom_range(0, 2))
					0:       gap_pct = 0;
					1:       gap_pct = 15;
					default: gap_pct = 40;
				endcase
				case ($urandom_range(0, 2))
					0:       stall_pct = 0;
					1:       stall_pct = 20;
					default: stall_pct = 60;
				endcase
				next_phase = chars_sent + PHASE_ITEMS;
			end
			// closing stretch runs at full rate on both sides
			if (chars_sent > ITEM_TARGET - PHASE_ITEMS) begin
				gap_pct   = 0;
				stall_pct = 0;
			end
			if ($urandom_range(0, 99) < 80)
				send_name($urandom_range(1, 4), -1, $urandom_range(0, 99) < 90,
					$urandom_range(0, 99) < 15);
			else
				send_noise();
		end
		drain();

		$display("%0d characters sent, %0d query id writes, %0d packet writes checked",
			chars_sent, id_writes, writes_checked);
		$display("%0d packets closed, %0d writes carried the overflow flag",
			packets_closed, overflow_writes);
		if (errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
